// ----- rtl/aes_block_cipher_defines.svh -----
// Assertion macros for the AES block cipher RTL.
// Included by modules that carry concurrent checks; needs signals named clock and reset.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define AES_ASSERT_IMPLY(lbl, ante, cons, msg)
`define AES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/aes_pkg.sv -----
// Shared types, constants, S-box tables and round functions for the AES block cipher.
// No dependencies.
package aes_pkg;

   localparam int NB = 4;               // columns in the state
   localparam int ROW_W = 32 * NB;      // one round key / state width
   localparam int ROWS = 15;            // round keys for up to 14 rounds

   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [7:0] GF_MSB = 8'h80;

   // register indexes
   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_KEY_W0 = 3'd1;
   localparam logic [2:0] CSR_KEY_W1 = 3'd2;
   localparam logic [2:0] CSR_KEY_W2 = 3'd3;
   localparam logic [2:0] CSR_KEY_W3 = 3'd4;

   // datapath operations
   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_ROUND = 2'd2;
   localparam logic [1:0] OP_FINAL = 2'd3;

   typedef struct packed {
      logic       step;
      logic       load;
      logic [2:0] word_idx;
      logic       rot;
      logic       sub4;
      logic [2:0] back_idx;
      logic [1:0] lane;
      logic       row_wr;
      logic       inv_row;
      logic [3:0] row_idx;
   } ke_cmd_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [3:0] rd_addr;
      logic [1:0] op;
      logic       out_wr;
   } dp_cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (((b & GF_MSB) != 8'h00) ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      logic [31:0] o;
      for (int k = 0; k < 4; k++) o[8*k +: 8] = SBOX[w[8*k +: 8]];
      return o;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] w);
      logic [7:0] a [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) a[k] = w[8*k +: 8];
      for (int r = 0; r < 4; r++) begin
         o[8*r +: 8] = xtime(a[r]) ^ xtime(a[(r + 1) & 3]) ^ a[(r + 1) & 3] ^
                       a[(r + 2) & 3] ^ a[(r + 3) & 3];
      end
      return o;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) begin
         a[k] = w[8*k +: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
      end
      for (int r = 0; r < 4; r++) begin
         // 14*a0 ^ 11*a1 ^ 13*a2 ^ 9*a3
         o[8*r +: 8] = (x8[r] ^ x4[r] ^ x2[r]) ^
                       (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3]) ^
                       (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3]) ^
                       (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
      end
      return o;
   endfunction

   function automatic logic [ROW_W-1:0] sub_shift(input logic [ROW_W-1:0] s, input logic inv);
      logic [ROW_W-1:0] t;
      logic [7:0] b;
      int src;
      for (int c = 0; c < NB; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
            b = s[8*(4*src + r) +: 8];
            t[8*(4*c + r) +: 8] = inv ? INV_SBOX[b] : SBOX[b];
         end
      end
      return t;
   endfunction

   function automatic logic [ROW_W-1:0] mix_state(input logic [ROW_W-1:0] s, input logic inv);
      logic [ROW_W-1:0] t;
      for (int c = 0; c < NB; c++) begin
         t[32*c +: 32] = inv ? inv_mix_col(s[32*c +: 32]) : mix_col(s[32*c +: 32]);
      end
      return t;
   endfunction

endpackage

// ----- rtl/aes_ctrl.sv -----
// Controller for the AES block cipher: key expansion sequencing and round sequencing.
// Depends on aes_pkg and aes_block_cipher_defines.svh.
`include "aes_block_cipher_defines.svh"
module aes_ctrl
   import aes_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [1:0] csr_size,
   output ke_cmd_type ke_cmd,
   output dp_cmd_type dp_cmd
);

   localparam logic [1:0] ST_EXPAND = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_ROUND = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] key_size_ff, key_size_in;
   logic [5:0] i_ff, i_in;
   logic [2:0] j_ff, j_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] addr_ff, addr_in;
   logic       dec_ff, dec_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [1:0] sel;
   logic [2:0] nk_m1;
   logic [3:0] nr;
   logic [5:0] last_word;
   logic       cfg_start;
   logic       out_free;
   logic [3:0] addr_step;

   assign sel = (key_size_ff == 2'd3) ? 2'd2 : key_size_ff;
   assign nk_m1 = 3'd3 + {sel, 1'b0};
   assign nr = 4'd10 + {1'b0, sel, 1'b0};
   assign last_word = {nr, 2'b11};
   assign cfg_start = csr_we && (csr_index <= CSR_KEY_W3);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign addr_step = dec_ff ? (addr_ff - 4'd1) : (addr_ff + 4'd1);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      key_size_in = key_size_ff;
      i_in = i_ff;
      j_in = j_ff;
      cnt_in = cnt_ff;
      addr_in = addr_ff;
      dec_in = dec_ff;
      ke_cmd = '0;
      dp_cmd = '0;
      dp_cmd.op = OP_HOLD;
      dp_cmd.rd_addr = addr_ff;

      unique case (state_ff)
         ST_EXPAND: begin
            ke_cmd.step = 1'b1;
            ke_cmd.load = (i_ff <= {3'b000, nk_m1});
            ke_cmd.word_idx = i_ff[2:0];
            ke_cmd.rot = !ke_cmd.load && (j_ff == 3'd0);
            ke_cmd.sub4 = !ke_cmd.load && (nk_m1 == 3'd7) && (j_ff == 3'd4);
            ke_cmd.back_idx = nk_m1;
            ke_cmd.lane = i_ff[1:0];
            ke_cmd.row_wr = (i_ff[1:0] == 2'b11);
            ke_cmd.row_idx = i_ff[5:2];
            ke_cmd.inv_row = (i_ff[5:2] != 4'd0) && (i_ff[5:2] != nr);
            i_in = i_ff + 6'd1;
            j_in = (j_ff == nk_m1) ? 3'd0 : j_ff + 3'd1;
            if (i_ff == last_word) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               dec_in = req_action;
               addr_in = req_action ? nr : 4'd0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            dp_cmd.rd_en = 1'b1;
            addr_in = addr_step;
            cnt_in = 4'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (cnt_ff == 4'd0) begin
               dp_cmd.op = OP_ADD;
            end else if (cnt_ff == nr) begin
               dp_cmd.op = OP_FINAL;
            end else begin
               dp_cmd.op = OP_ROUND;
            end
            if (cnt_ff != nr) begin
               dp_cmd.rd_en = 1'b1;
               addr_in = addr_step;
               cnt_in = cnt_ff + 4'd1;
            end else if (out_free) begin
               dp_cmd.out_wr = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_EXPAND;
         end
      endcase

      // any key or key-size write restarts the schedule
      if (cfg_start) begin
         if (csr_index == CSR_KEY_SIZE) key_size_in = csr_size;
         i_in = 6'd0;
         j_in = 3'd0;
         state_in = ST_EXPAND;
      end
   end

   assign rsp_valid_in = dp_cmd.out_wr || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXPAND;
         key_size_ff <= 2'd0;
         i_ff <= 6'd0;
         j_ff <= 3'd0;
         cnt_ff <= 4'd0;
         addr_ff <= 4'd0;
         dec_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_size_ff <= key_size_in;
         i_ff <= i_in;
         j_ff <= j_in;
         cnt_ff <= cnt_in;
         addr_ff <= addr_in;
         dec_ff <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `AES_ASSERT_IMPLY(a_out_slot_free, dp_cmd.out_wr, !rsp_valid_ff || rsp_ready, "result overwritten")
   `AES_ASSERT_NEXT(a_accept_fetch, req_valid && req_ready && !cfg_start, state_ff == ST_FETCH, "no fetch after accept")
   `AES_ASSERT_IMPLY(a_expand_bound, state_ff == ST_EXPAND, i_ff <= last_word, "key schedule overrun")
   `AES_ASSERT_IMPLY(a_round_bound, state_ff == ST_ROUND, cnt_ff <= nr, "round count overrun")

endmodule

// ----- rtl/aes_kexp.sv -----
// Key schedule datapath: key registers, word window, round constant, row assembly.
// Depends on aes_pkg.
module aes_kexp
   import aes_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   input  ke_cmd_type       ke_cmd,
   output logic [ROW_W-1:0] row_fwd,
   output logic [ROW_W-1:0] row_inv
);

   logic [63:0] key_word_ff [4];
   logic [31:0] win_ff [8];
   logic [31:0] rowbuf_ff [3];
   logic [7:0]  rcon_ff;

   logic [63:0] kw;
   logic [31:0] key_half, prev, back, t, new_word;

   assign kw = key_word_ff[ke_cmd.word_idx[2:1]];
   assign key_half = ke_cmd.word_idx[0] ? kw[63:32] : kw[31:0];
   assign prev = win_ff[0];
   assign back = win_ff[ke_cmd.back_idx];

   always_comb begin
      if (ke_cmd.rot) begin
         t = sub_word({prev[7:0], prev[31:8]}) ^ {24'h000000, rcon_ff};
      end else if (ke_cmd.sub4) begin
         t = sub_word(prev);
      end else begin
         t = prev;
      end
      new_word = ke_cmd.load ? key_half : (back ^ t);
   end

   assign row_fwd = {new_word, rowbuf_ff[2], rowbuf_ff[1], rowbuf_ff[0]};

   always_comb begin
      for (int c = 0; c < NB; c++) begin
         row_inv[32*c +: 32] = ke_cmd.inv_row ? inv_mix_col(row_fwd[32*c +: 32])
                                              : row_fwd[32*c +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) key_word_ff[k] <= 64'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_W0: key_word_ff[0] <= csr_wdata;
            CSR_KEY_W1: key_word_ff[1] <= csr_wdata;
            CSR_KEY_W2: key_word_ff[2] <= csr_wdata;
            CSR_KEY_W3: key_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ke_cmd.step) begin
         win_ff[0] <= new_word;
         for (int k = 1; k < 8; k++) win_ff[k] <= win_ff[k-1];
         if (ke_cmd.lane != 2'b11) rowbuf_ff[ke_cmd.lane] <= new_word;
         if (ke_cmd.load) begin
            rcon_ff <= RCON_INIT;
         end else if (ke_cmd.rot) begin
            rcon_ff <= xtime(rcon_ff);
         end
      end
   end

endmodule

// ----- rtl/aes_dp.sv -----
// Cipher datapath: round key memories, state register and result register.
// Depends on aes_pkg.
module aes_dp
   import aes_pkg::*;
(
   input  logic             clock,
   input  dp_cmd_type       dp_cmd,
   input  ke_cmd_type       ke_cmd,
   input  logic [ROW_W-1:0] row_fwd,
   input  logic [ROW_W-1:0] row_inv,
   input  logic             req_action,
   input  logic [63:0]      req_in_block_lo,
   input  logic [63:0]      req_in_block_hi,
   output logic [63:0]      rsp_out_block_lo,
   output logic [63:0]      rsp_out_block_hi
);

   logic [ROW_W-1:0] fkey_mem [ROWS];
   logic [ROW_W-1:0] ikey_mem [ROWS];
   logic [ROW_W-1:0] fkey_ff, ikey_ff;
   logic [ROW_W-1:0] state_ff, state_in;
   logic [ROW_W-1:0] out_ff;
   logic             dec_ff;
   logic [ROW_W-1:0] rkey, subbed;

   assign rkey = dec_ff ? ikey_ff : fkey_ff;
   assign subbed = sub_shift(state_ff, dec_ff);

   always_ff @(posedge clock) begin
      if (ke_cmd.row_wr) begin
         fkey_mem[ke_cmd.row_idx] <= row_fwd;
         ikey_mem[ke_cmd.row_idx] <= row_inv;
      end
      if (dp_cmd.rd_en) begin
         fkey_ff <= fkey_mem[dp_cmd.rd_addr];
         ikey_ff <= ikey_mem[dp_cmd.rd_addr];
      end
   end

   always_comb begin
      case (dp_cmd.op)
         OP_ADD:   state_in = state_ff ^ rkey;
         OP_ROUND: state_in = mix_state(subbed, dec_ff) ^ rkey;
         default:  state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         state_ff <= {req_in_block_hi, req_in_block_lo};
         dec_ff <= req_action;
      end else begin
         state_ff <= state_in;
      end
      if (dp_cmd.out_wr) out_ff <= subbed ^ rkey;
   end

   assign rsp_out_block_lo = out_ff[63:0];
   assign rsp_out_block_hi = out_ff[127:64];

endmodule

// ----- rtl/aes_block_cipher.sv -----
// Top level of the AES block cipher (ECB, 128/192/256-bit keys, encrypt and decrypt).
// Depends on aes_pkg, aes_ctrl, aes_kexp and aes_dp.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_action, req_in_block_lo/hi
//   rsp      out        rsp_valid / rsp_ready   rsp_out_block_lo/hi
//   csr      in         csr_we                  csr_index, csr_wdata
//
// One block at a time through a single round unit that does one round per cycle.
// The round key read from the key memory adds a fetch step ahead of the rounds, and a new
// block is accepted only after the previous one has been written to the result register.
// After reset and after every key or key-size write the key schedule runs one word
// per cycle, 44, 52 or 60 words, with req_ready low.
// Synchronous active-high reset. A finished block waits in the result register;
// the next item is taken meanwhile and stalls only at its last round until rsp drains.
module aes_block_cipher
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_in_block_lo,
   input  logic [63:0] req_in_block_hi,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_block_lo,
   output logic [63:0] rsp_out_block_hi,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   ke_cmd_type       ke_cmd;
   dp_cmd_type       dp_cmd;
   logic [ROW_W-1:0] row_fwd, row_inv;

   // sequencing for both the key schedule and the rounds
   aes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_size   (csr_wdata[1:0]),
      .ke_cmd     (ke_cmd),
      .dp_cmd     (dp_cmd)
   );

   // key registers and round key generation, one row every four words
   aes_kexp u_kexp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ke_cmd    (ke_cmd),
      .row_fwd   (row_fwd),
      .row_inv   (row_inv)
   );

   // round key memories and the iterated round
   aes_dp u_dp (
      .clock            (clock),
      .dp_cmd           (dp_cmd),
      .ke_cmd           (ke_cmd),
      .row_fwd          (row_fwd),
      .row_inv          (row_inv),
      .req_action       (req_action),
      .req_in_block_lo  (req_in_block_lo),
      .req_in_block_hi  (req_in_block_hi),
      .rsp_out_block_lo (rsp_out_block_lo),
      .rsp_out_block_hi (rsp_out_block_hi)
   );

endmodule
